### src/tdda_pkg.sv
// ----------------------------------------------------------------------------
// Table-driven DFA acceptor: shared definitions
// Command and status codes, field widths, item and result records.
// ----------------------------------------------------------------------------
package tdda_pkg;

    localparam int DEF_MAX_STATES  = 128;
    localparam int DEF_MAX_SYMBOLS = 16;

    localparam int CMD_W   = 3;
    localparam int CODE_W  = 8;
    localparam int STATE_W = 7;
    localparam int SIDX_W  = 4;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    localparam int OUT_FIFO_DEPTH = 4;

    localparam logic [CNT_W-1:0] SYMCNT_RESET = 5'd1;

    localparam logic [CMD_W-1:0] CMD_LOAD_ALPHA = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_TRANS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_FINAL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SYMBOL     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_END_WORD   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_MOVED     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_TRANS  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_IGNORED   = 2'd3;

    localparam logic KIND_TRACE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CODE_W-1:0]  symbol_code;
        logic [STATE_W-1:0] state_index;
        logic [SIDX_W-1:0]  symbol_index;
        logic [STATE_W-1:0] next_state;
        logic               flag_value;
    } t_item;

    typedef struct packed {
        logic               result_kind;
        logic [STATE_W-1:0] from_state;
        logic [SIDX_W-1:0]  matched_symbol;
        logic [STATE_W-1:0] to_state;
        logic [STAT_W-1:0]  step_status;
        logic               accepted;
        logic               empty_word;
    } t_result;

    typedef struct packed {
        logic       clr_busy;
        logic [1:0] inflight;
    } t_step_status;

endpackage

### src/tdda_alphabet.sv
// ----------------------------------------------------------------------------
// Alphabet table and symbol matcher
// Holds the alphabet entries and finds the lowest enabled entry that
// equals the incoming character code.
// ----------------------------------------------------------------------------
module tdda_alphabet #(
    parameter int  MAX_SYMBOLS = tdda_pkg::DEF_MAX_SYMBOLS,
    localparam int YW          = $clog2(MAX_SYMBOLS)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [YW-1:0]               i_wr_idx,
    input  logic [tdda_pkg::CODE_W-1:0] i_wr_code,
    input  logic [tdda_pkg::CODE_W-1:0] i_code,
    input  logic [tdda_pkg::CNT_W-1:0]  i_symcnt,
    output logic                        o_found,
    output logic [YW-1:0]               o_idx
);
    import tdda_pkg::*;

    logic [CODE_W-1:0]      r_alpha [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0] hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_alpha[i_wr_idx] <= i_wr_code;
        end
    end

    // Entries at or above the symbol count take no part in matching.
    always_comb begin
        for (int e = 0; e < MAX_SYMBOLS; e++) begin
            hit[e] = (r_alpha[e] == i_code) && (e < 32'(i_symcnt));
        end
    end

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int e = MAX_SYMBOLS - 1; e >= 0; e--) begin
            if (hit[e]) begin
                o_found = 1'b1;
                o_idx   = YW'(e);
            end
        end
    end

endmodule

### src/tdda_step.sv
// ----------------------------------------------------------------------------
// DFA step engine
// Input register, table writes, transition and final-flag memories, and the
// state update. The next state leaving stage two is forwarded straight into
// the transition memory read address of the item in stage one.
// ----------------------------------------------------------------------------
module tdda_step #(
    parameter int MAX_STATES  = tdda_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = tdda_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_vld,
    input  tdda_pkg::t_item            i_item,
    input  logic [tdda_pkg::CNT_W-1:0] i_symcnt,
    output logic                       o_res_vld,
    output tdda_pkg::t_result          o_res,
    output tdda_pkg::t_step_status     o_status
);
    import tdda_pkg::*;

    localparam int SW = $clog2(MAX_STATES);
    localparam int YW = $clog2(MAX_SYMBOLS);
    localparam int TD = MAX_STATES * MAX_SYMBOLS;
    localparam int AW = $clog2(TD);

    // Stage one: accepted item.
    logic  r_s1_vld;
    t_item r_s1;

    // Stage two: symbol or end-of-word waiting for its memory reads.
    logic          r_s2_vld;
    logic          r_s2_end;
    logic          r_s2_found;
    logic [YW-1:0] r_s2_idx;

    // Automaton state.
    logic [SW-1:0] r_state, n_state;
    logic          r_rej, n_rej;
    logic          r_started, n_started;

    // Final-flag clearing sweep after reset.
    logic          r_clr_busy;
    logic [SW-1:0] r_clr_addr;

    logic [SW:0]   trans_mem [TD];
    logic [SW:0]   r_trans_rd;
    logic          final_mem [MAX_STATES];
    logic          r_final_rd;

    logic [SW+STATE_W-1:0] st_ext, nx_ext;
    logic [YW+SIDX_W-1:0]  si_ext;
    logic [SW-1:0]         st_s, nx_s;
    logic [YW-1:0]         si_s;
    logic                  st_ok, si_ok, nx_ok;

    logic                  alpha_we;
    logic                  match_found;
    logic [YW-1:0]         match_idx;

    logic                  trans_we;
    logic [AW-1:0]         trans_wa, trans_ra;
    logic [SW:0]           trans_wd;
    logic                  final_we, final_wd;
    logic [SW-1:0]         final_wa;
    logic                  s1_res;

    logic [SW-1:0]         target;
    logic                  no_trans;
    logic [SW+STATE_W-1:0] from_ext, target_ext;
    logic [YW+SIDX_W-1:0]  idx_ext;
    t_result               res;

    // ---------------------------------------------------------------- stage 1
    assign st_ext = {{SW{1'b0}}, r_s1.state_index};
    assign nx_ext = {{SW{1'b0}}, r_s1.next_state};
    assign si_ext = {{YW{1'b0}}, r_s1.symbol_index};
    assign st_s   = st_ext[SW-1:0];
    assign nx_s   = nx_ext[SW-1:0];
    assign si_s   = si_ext[YW-1:0];
    assign st_ok  = 32'(r_s1.state_index) < MAX_STATES;
    assign nx_ok  = 32'(r_s1.next_state) < MAX_STATES;
    assign si_ok  = 32'(r_s1.symbol_index) < MAX_SYMBOLS;

    assign alpha_we = r_s1_vld && (r_s1.command == CMD_LOAD_ALPHA) && si_ok;

    tdda_alphabet #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_alphabet (
        .i_clk     (i_clk),
        .i_we      (alpha_we),
        .i_wr_idx  (si_s),
        .i_wr_code (r_s1.symbol_code),
        .i_code    (r_s1.symbol_code),
        .i_symcnt  (i_symcnt),
        .o_found   (match_found),
        .o_idx     (match_idx)
    );

    assign trans_we = r_s1_vld && (r_s1.command == CMD_LOAD_TRANS) && st_ok && si_ok
                      && (r_s1.flag_value || nx_ok);
    assign trans_wa = AW'(32'(st_s) * MAX_SYMBOLS + 32'(si_s));
    assign trans_wd = r_s1.flag_value ? {1'b1, {SW{1'b0}}} : {1'b0, nx_s};

    // Reads use the state that stage two is producing in this same cycle.
    assign trans_ra = AW'(32'(n_state) * MAX_SYMBOLS + 32'(match_idx));

    assign final_we = r_clr_busy || (r_s1_vld && (r_s1.command == CMD_SET_FINAL) && st_ok);
    assign final_wa = r_clr_busy ? r_clr_addr : st_s;
    assign final_wd = r_clr_busy ? 1'b0 : r_s1.flag_value;

    assign s1_res = r_s1_vld
                    && ((r_s1.command == CMD_SYMBOL) || (r_s1.command == CMD_END_WORD));

    always_ff @(posedge i_clk) begin
        if (trans_we) begin
            trans_mem[trans_wa] <= trans_wd;
        end
        r_trans_rd <= trans_mem[trans_ra];
    end

    always_ff @(posedge i_clk) begin
        if (final_we) begin
            final_mem[final_wa] <= final_wd;
        end
        r_final_rd <= final_mem[n_state];
    end

    always_ff @(posedge i_clk) begin
        r_s1       <= i_item;
        r_s2_end   <= (r_s1.command == CMD_END_WORD);
        r_s2_found <= match_found;
        r_s2_idx   <= match_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_state    <= '0;
            r_rej      <= 1'b0;
            r_started  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_s1_vld  <= i_in_vld;
            r_s2_vld  <= s1_res;
            r_state   <= n_state;
            r_rej     <= n_rej;
            r_started <= n_started;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == SW'(MAX_STATES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 2
    assign target     = r_trans_rd[SW-1:0];
    assign no_trans   = r_trans_rd[SW];
    assign from_ext   = {{STATE_W{1'b0}}, r_state};
    assign target_ext = {{STATE_W{1'b0}}, target};
    assign idx_ext    = {{SIDX_W{1'b0}}, r_s2_idx};

    always_comb begin
        n_state   = r_state;
        n_rej     = r_rej;
        n_started = r_started;

        res.result_kind    = KIND_TRACE;
        res.from_state     = from_ext[STATE_W-1:0];
        res.matched_symbol = '0;
        res.to_state       = from_ext[STATE_W-1:0];
        res.step_status    = STAT_MOVED;
        res.accepted       = 1'b0;
        res.empty_word     = 1'b0;

        if (r_s2_vld) begin
            if (r_s2_end) begin
                res.result_kind = KIND_VERDICT;
                res.accepted    = !r_rej && r_final_rd;
                res.empty_word  = !r_started;
                n_state         = '0;
                n_rej           = 1'b0;
                n_started       = 1'b0;
            end else begin
                n_started = 1'b1;
                priority if (r_rej) begin
                    res.step_status = STAT_IGNORED;
                end else if (!r_s2_found) begin
                    res.step_status = STAT_NOT_FOUND;
                    n_rej           = 1'b1;
                end else if (no_trans) begin
                    res.matched_symbol = idx_ext[SIDX_W-1:0];
                    res.step_status    = STAT_NO_TRANS;
                    n_rej              = 1'b1;
                end else begin
                    res.matched_symbol = idx_ext[SIDX_W-1:0];
                    res.to_state       = target_ext[STATE_W-1:0];
                    n_state            = target;
                end
            end
        end
    end

    assign o_res_vld         = r_s2_vld;
    assign o_res             = res;
    assign o_status.clr_busy = r_clr_busy;
    assign o_status.inflight = {1'b0, r_s1_vld} + {1'b0, r_s2_vld};

    // ------------------------------------------------------------- checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in_vld)
        else $error("item accepted during the final-flag clearing sweep");

    a_verdict_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_end) |=> (r_state == '0) && !r_rej && !r_started)
        else $error("automaton not returned to its start after a verdict");

    a_symbol_starts_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && !r_s2_end) |=> r_started)
        else $error("word not marked started after a symbol");

    a_unknown_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && !r_s2_end && !r_s2_found) |=> r_rej)
        else $error("unknown symbol did not reject the word");

endmodule

### src/tdda_obuf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Small queue of finished results in front of the output stream.
// ----------------------------------------------------------------------------
module tdda_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tdda_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_vld,
    output tdda_pkg::t_result o_data,
    output logic [$clog2(tdda_pkg::OUT_FIFO_DEPTH+1)-1:0] o_count
);
    import tdda_pkg::*;

    localparam int PW = $clog2(OUT_FIFO_DEPTH);
    localparam int CW = $clog2(OUT_FIFO_DEPTH + 1);

    t_result       r_mem [OUT_FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_vld   = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count < CW'(OUT_FIFO_DEPTH)))
        else $error("result pushed into a full buffer");

endmodule

### src/table_driven_dfa_acceptor_unit.sv
// ----------------------------------------------------------------------------
// Table-driven DFA acceptor
// Programmable automaton: loads fill the alphabet, transition and final-flag
// tables; word symbols give trace results and end-of-word gives a verdict.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                    Moves
//  s         in         i_s_t*, o_s_tready       commands, loads and word symbols
//  m         out        o_m_t*, i_m_tready       trace steps and verdicts
//  cfg       in         i_cfg_*, o_cfg_ready     symbol count register
//
//  One request per cycle is taken while o_s_tready is high; a request moves
//  through stage one and stage two, then its result enters the result buffer.
//  The rate is set by the transition memory read: its next state is forwarded
//  into the read address of the next symbol. After reset the final flags are
//  cleared while o_s_tready is low. A four-entry result buffer absorbs output
//  stalls; o_s_tready drops once buffered plus in-flight requests reach four.
// ----------------------------------------------------------------------------
module table_driven_dfa_acceptor_unit #(
    parameter int MAX_STATES  = tdda_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = tdda_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // symbol_code, state_index, symbol_index, next_state, flag_value
    input  logic [tdda_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // command
    input  logic [tdda_pkg::CMD_W-1:0]        i_s_tuser,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // from_state, matched_symbol, to_state, step_status, accepted, empty_word
    output logic [tdda_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // result_kind
    output logic [0:0]                        o_m_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [tdda_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready
);
    import tdda_pkg::*;

    localparam int CW = $clog2(OUT_FIFO_DEPTH + 1);

    logic [CNT_W-1:0] r_symcnt;
    t_item            item;
    logic             in_acc;
    logic             res_vld;
    t_result          res;
    t_step_status     status;
    logic             out_pop;
    t_result          out_res;
    logic [CW-1:0]    buf_count;
    logic [CW:0]      occupancy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symcnt <= SYMCNT_RESET;
        end else if (i_cfg_valid) begin
            r_symcnt <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    assign item.command      = i_s_tuser;
    assign item.symbol_code  = i_s_tdata[7:0];
    assign item.state_index  = i_s_tdata[14:8];
    assign item.symbol_index = i_s_tdata[18:15];
    assign item.next_state   = i_s_tdata[25:19];
    assign item.flag_value   = i_s_tdata[26];

    // Every request in flight is counted, so the buffer always has room.
    assign occupancy  = {1'b0, buf_count} + (CW + 1)'(status.inflight);
    assign o_s_tready = !status.clr_busy && (occupancy < (CW + 1)'(OUT_FIFO_DEPTH));
    assign in_acc     = i_s_tvalid && o_s_tready;

    tdda_step #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (in_acc),
        .i_item    (item),
        .i_symcnt  (r_symcnt),
        .o_res_vld (res_vld),
        .o_res     (res),
        .o_status  (status)
    );

    assign out_pop = o_m_tvalid && i_m_tready;

    tdda_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_data  (res),
        .i_pop   (out_pop),
        .o_vld   (o_m_tvalid),
        .o_data  (out_res),
        .o_count (buf_count)
    );

    assign o_m_tdata = {2'b00, out_res.empty_word, out_res.accepted, out_res.step_status,
                        out_res.to_state, out_res.matched_symbol, out_res.from_state};
    assign o_m_tuser = out_res.result_kind;

endmodule
